// ===== sv/u8d_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
package u8d_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 31;
    localparam int unsigned REM_W  = 3;
    localparam int unsigned CONT_W = 6;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_ERR = 2'd1,
        ST_END = 2'd2
    } status_t;

    typedef struct packed {
        logic [CP_W-1:0]  acc;
        logic [REM_W-1:0] remaining;
    } dec_state_t;

    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] code_point;
        status_t         status;
    } dec_result_t;

    // Top two bits of a continuation byte
    localparam logic [1:0] CONT_PREFIX = 2'b10;

endpackage

// ===== sv/u8d_step.sv =====
// Combinational decode of one byte against the open sequence state.
module u8d_step (
    input  logic [u8d_pkg::BYTE_W-1:0] byte_in,
    input  logic                       end_of_stream,
    input  u8d_pkg::dec_state_t        state_cur,
    output u8d_pkg::dec_state_t        state_next,
    output u8d_pkg::dec_result_t       result
);
    import u8d_pkg::*;

    logic [CP_W-1:0]  acc_shift;
    logic [REM_W-1:0] rem_dec;

    assign acc_shift = {state_cur.acc[CP_W-CONT_W-1:0], byte_in[CONT_W-1:0]};
    assign rem_dec   = state_cur.remaining - REM_W'(1);

    always_comb begin
        state_next        = state_cur;
        result.emit       = 1'b0;
        result.code_point = '0;
        result.status     = ST_OK;

        if (end_of_stream) begin
            result.emit   = 1'b1;
            result.status = (state_cur.remaining != '0) ? ST_ERR : ST_END;
        end else if (state_cur.remaining == '0) begin
            case (byte_in) inside
                [8'h00:8'h7F]: begin
                    result.emit       = 1'b1;
                    result.code_point = CP_W'(byte_in);
                end
                [8'h80:8'hBF], [8'hFE:8'hFF]: begin
                    result.emit   = 1'b1;
                    result.status = ST_ERR;
                end
                [8'hC0:8'hDF]: begin
                    state_next.acc       = CP_W'(byte_in & 8'h1F);
                    state_next.remaining = REM_W'(1);
                end
                [8'hE0:8'hEF]: begin
                    state_next.acc       = CP_W'(byte_in & 8'h0F);
                    state_next.remaining = REM_W'(2);
                end
                [8'hF0:8'hF7]: begin
                    state_next.acc       = CP_W'(byte_in & 8'h07);
                    state_next.remaining = REM_W'(3);
                end
                [8'hF8:8'hFB]: begin
                    state_next.acc       = CP_W'(byte_in & 8'h03);
                    state_next.remaining = REM_W'(4);
                end
                default: begin
                    // 0xFC and 0xFD: six-byte lead
                    state_next.acc       = CP_W'(byte_in & 8'h01);
                    state_next.remaining = REM_W'(5);
                end
            endcase
        end else if (byte_in[BYTE_W-1 -: 2] != CONT_PREFIX) begin
            result.emit   = 1'b1;
            result.status = ST_ERR;
        end else if (rem_dec == '0) begin
            result.emit       = 1'b1;
            result.code_point = acc_shift;
        end else begin
            state_next.acc       = acc_shift;
            state_next.remaining = rem_dec;
        end

        // Any result closes the sequence
        if (result.emit) begin
            state_next.acc       = '0;
            state_next.remaining = '0;
        end
    end

endmodule

// ===== sv/u8d_out_reg.sv =====
// Result register holding one decoded item until the sink takes it.
module u8d_out_reg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  logic [u8d_pkg::CP_W-1:0]     code_point_in,
    input  u8d_pkg::status_t             status_in,
    output logic                         load_ready,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [u8d_pkg::CP_W-1:0]     code_point_out,
    output u8d_pkg::status_t             status_out
);
    import u8d_pkg::*;

    logic            valid_reg;
    logic [CP_W-1:0] cp_reg;
    status_t         status_reg;

    assign load_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_ready) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && load_ready) begin
            cp_reg     <= code_point_in;
            status_reg <= status_in;
        end
    end

    assign m_tvalid       = valid_reg;
    assign code_point_out = cp_reg;
    assign status_out     = status_reg;

endmodule

// ===== sv/utf8_stream_decoder_top.sv =====
// Path: input register, combinational decode step, result register, then m_.
// Throughput: one byte per cycle unless a result is blocked; decode is combinational.
// A byte that completes no code point gives no result and frees its slot at once.
// Back-pressure on m_ stalls the input register only when the result register is full.
// Reset: aresetn synchronous active low; clears valid flags and the open sequence.
module utf8_stream_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic [0:0]  s_tuser,   // [0] end_of_stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] code_point, [31] zero
    output logic [1:0]  m_tuser    // [1:0] status
);
    import u8d_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_eos_reg;
    dec_state_t        state_reg;
    dec_state_t        state_next;
    dec_result_t       res;
    logic              out_ready;
    logic              advance;
    logic [CP_W-1:0]   out_cp;
    status_t           out_status;

    u8d_step u_step (
        .byte_in       (in_byte_reg),
        .end_of_stream (in_eos_reg),
        .state_cur     (state_reg),
        .state_next    (state_next),
        .result        (res)
    );

    // Advance the held byte unless its result has nowhere to go
    assign advance  = in_valid_reg && (!res.emit || out_ready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_eos_reg  <= s_tuser[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    u8d_out_reg u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (in_valid_reg && res.emit),
        .code_point_in  (res.code_point),
        .status_in      (res.status),
        .load_ready     (out_ready),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .code_point_out (out_cp),
        .status_out     (out_status)
    );

    assign m_tdata = {1'b0, out_cp};
    assign m_tuser = out_status;

    a_err_cp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_status != ST_OK) |-> (out_cp == '0))
        else $error("error or end result carries a nonzero code point");

    a_boundary_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res.emit) |=> (state_reg.remaining == '0 && state_reg.acc == '0))
        else $error("sequence state not cleared after a result");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && res.emit && m_tvalid && !m_tready))
        else $error("input stalled without a blocked result");

    a_end_only_at_boundary: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res.emit && res.status == ST_END) |-> (state_reg.remaining == '0))
        else $error("end of stream reported inside a sequence");

endmodule
